FILE: hdl/plcs_pkg.sv
// shared constants, types and register codes for the pivot level crossover block
// no dependencies; every other file refers to it by scoped names
package plcs_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int LEVEL_COUNT  = 8;
  localparam int HIST_DEPTH   = 3;

  localparam int PRICE_W    = 31;
  localparam int AVG_W      = 32;
  localparam int FLAG_W     = LEVEL_COUNT;
  localparam int LSPAN_W    = 5;
  localparam int RSPAN_W    = 6;
  localparam int SPAN_W     = RSPAN_W + 1;
  localparam int ADDR_W     = $clog2(WINDOW_DEPTH);
  localparam int FILL_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W      = (FILL_W > SPAN_W) ? FILL_W : SPAN_W;
  localparam int LVL_W      = $clog2(LEVEL_COUNT);
  localparam int HIDX_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPAN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SLOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_QUICK = 2'd2;

  localparam logic [LSPAN_W-1:0] LEFT_SPAN_RST   = 5'd4;
  localparam logic [RSPAN_W-1:0] RIGHT_SLOW_RST  = 6'd4;
  localparam logic [RSPAN_W-1:0] RIGHT_QUICK_RST = 6'd2;

  typedef logic [PRICE_W-1:0] price_t;

  // one step of the window scan
  typedef struct packed {
    logic               en;
    logic [SPAN_W-1:0]  d;
    logic [SPAN_W-1:0]  span_q;
    logic [SPAN_W-1:0]  span_s;
    logic [RSPAN_W-1:0] right_q;
    logic [RSPAN_W-1:0] right_s;
  } scan_ctl_t;

  typedef struct packed {
    price_t mx_q;
    price_t mn_q;
    price_t mid_q;
    price_t mx_s;
    price_t mn_s;
    price_t mid_s;
    price_t c2;
  } scan_res_t;

  // one level evaluation step
  typedef struct packed {
    logic             step;
    logic [LVL_W-1:0] k;
    logic             warm_q;
    logic             warm_s;
    logic             armed;
    logic             rise;
    logic             fall;
  } lvl_ctl_t;

endpackage

FILE: hdl/plcs_ifc.sv
// request channel interfaces of the pivot level crossover block
// depends on plcs_pkg for field widths
interface plcs_in_if;
  logic                               valid;
  logic                               ready;
  logic [plcs_pkg::PRICE_W-1:0]       close_price;
  logic signed [plcs_pkg::AVG_W-1:0]  avg_value;
  modport source(output valid, close_price, avg_value, input ready);
  modport sink(input valid, close_price, avg_value, output ready);
endinterface

interface plcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [plcs_pkg::FLAG_W-1:0] buy_flags;
  logic [plcs_pkg::FLAG_W-1:0] sell_flags;
  modport source(output valid, buy_flags, sell_flags, input ready);
  modport sink(input valid, buy_flags, sell_flags, output ready);
endinterface

interface plcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [plcs_pkg::CFG_IDX_W-1:0]  index;
  logic [plcs_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/pivot_level_crossover_signals.sv
// takes one request at a time, only while idle; the scan reads the closes 0 to scan_end samples
//   back, scan_end the larger of left_span + right_span_slow, left_span + right_span_quick and 2
// flow: one close a cycle through the scan unit, then one of eight levels a cycle, the last
//   one held while a result waits
// reset: synchronous; spans to defaults, levels cleared, window reads zero until written
// top level; depends on plcs_pkg, plcs_ifc, plcs_ram, plcs_scan and plcs_levels
module pivot_level_crossover_signals (
  input  logic       clk,
  input  logic       rst,
  plcs_cfg_if.sink   cfg,
  plcs_in_if.sink    samples,
  plcs_out_if.source results
);

  localparam int AW    = plcs_pkg::ADDR_W;
  localparam int SW    = plcs_pkg::SPAN_W;
  localparam int FW    = plcs_pkg::FILL_W;
  localparam int CW    = plcs_pkg::CMP_W;
  localparam int LW    = plcs_pkg::LVL_W;
  localparam int NW    = plcs_pkg::CNT_W;
  localparam int DEPTH = plcs_pkg::WINDOW_DEPTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_LEVEL = 2'd2;

  localparam logic [LW-1:0] LAST_LVL = LW'(plcs_pkg::LEVEL_COUNT - 1);

  logic [plcs_pkg::LSPAN_W-1:0] left_span;
  logic [plcs_pkg::RSPAN_W-1:0] right_span_slow;
  logic [plcs_pkg::RSPAN_W-1:0] right_span_quick;

  logic [1:0]                        state;
  logic [AW-1:0]                     head;
  logic [AW-1:0]                     head_next;
  logic [FW-1:0]                     fill;
  logic [NW-1:0]                     sample_count;
  plcs_pkg::price_t                  close_r;
  logic signed [plcs_pkg::AVG_W-1:0] avg_r;
  logic signed [plcs_pkg::AVG_W-1:0] prev_avg;
  logic [SW-1:0]                     scan_d;
  logic                              pend_en;
  logic [SW-1:0]                     pend_d;
  logic [LW-1:0]                     k;
  logic [plcs_pkg::FLAG_W-1:0]       buy_acc;
  logic [plcs_pkg::FLAG_W-1:0]       sell_acc;
  logic [plcs_pkg::FLAG_W-1:0]       buy_next;
  logic [plcs_pkg::FLAG_W-1:0]       sell_next;

  logic [SW-1:0]     span_q;
  logic [SW-1:0]     span_s;
  logic [SW-1:0]     scan_end;
  logic [AW-1:0]     d_a;
  logic [AW:0]       rd_sum;
  logic [AW-1:0]     rd_addr;
  plcs_pkg::price_t  rd_data;
  plcs_pkg::price_t  scan_val;
  logic              accept;
  logic              step_ok;
  logic              buy_bit;
  logic              sell_bit;

  plcs_pkg::scan_ctl_t scan_ctl;
  plcs_pkg::scan_res_t scan_res;
  plcs_pkg::lvl_ctl_t  lvl_ctl;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    span_q   = SW'(left_span) + SW'(right_span_quick);
    span_s   = SW'(left_span) + SW'(right_span_slow);
    scan_end = (span_q > span_s) ? span_q : span_s;
    if (scan_end < SW'(2)) scan_end = SW'(2);
    head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    // window slot d samples back, wrapping below slot zero
    d_a = AW'(scan_d);
    if (d_a <= head) begin
      rd_sum = {1'b0, head} - {1'b0, d_a};
    end else begin
      rd_sum = {1'b0, head} + (AW + 1)'(DEPTH) - {1'b0, d_a};
    end
    rd_addr  = rd_sum[AW-1:0];
    // slots not yet written read as zero
    scan_val = (CW'(pend_d) < CW'(fill)) ? rd_data : '0;
  end

  plcs_ram u_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (head_next),
    .wr_data (samples.close_price),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    scan_ctl.en      = pend_en;
    scan_ctl.d       = pend_d;
    scan_ctl.span_q  = span_q;
    scan_ctl.span_s  = span_s;
    scan_ctl.right_q = right_span_quick;
    scan_ctl.right_s = right_span_slow;
  end

  plcs_scan u_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .value (scan_val),
    .res   (scan_res)
  );

  // the last level waits until the result register is free
  assign step_ok = !((k == LAST_LVL) && results.valid && !results.ready);

  always_comb begin
    lvl_ctl.step   = (state == ST_LEVEL) && step_ok;
    lvl_ctl.k      = k;
    lvl_ctl.warm_q = (sample_count >= NW'(span_q));
    lvl_ctl.warm_s = (sample_count >= NW'(span_s));
    lvl_ctl.armed  = (sample_count >= NW'(2));
    lvl_ctl.rise   = (close_r > scan_res.c2);
    lvl_ctl.fall   = (close_r < scan_res.c2);
  end

  plcs_levels u_levels (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lvl_ctl),
    .res      (scan_res),
    .avg      (avg_r),
    .prev_avg (prev_avg),
    .buy      (buy_bit),
    .sell     (sell_bit)
  );

  always_comb begin
    buy_next     = buy_acc;
    sell_next    = sell_acc;
    buy_next[k]  = buy_bit;
    sell_next[k] = sell_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_span        <= plcs_pkg::LEFT_SPAN_RST;
      right_span_slow  <= plcs_pkg::RIGHT_SLOW_RST;
      right_span_quick <= plcs_pkg::RIGHT_QUICK_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        plcs_pkg::REG_LEFT_SPAN:   left_span        <= cfg.data[plcs_pkg::LSPAN_W-1:0];
        plcs_pkg::REG_RIGHT_SLOW:  right_span_slow  <= cfg.data;
        plcs_pkg::REG_RIGHT_QUICK: right_span_quick <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      fill          <= '0;
      sample_count  <= '0;
      prev_avg      <= '0;
      scan_d        <= '0;
      pend_en       <= 1'b0;
      k             <= '0;
      results.valid <= 1'b0;
    end else begin
      if (lvl_ctl.step && (k == LAST_LVL)) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          pend_en <= 1'b0;
          if (accept) begin
            head     <= head_next;
            if (fill < FW'(DEPTH)) fill <= fill + 1'b1;
            close_r  <= samples.close_price;
            avg_r    <= samples.avg_value;
            scan_d   <= '0;
            buy_acc  <= '0;
            sell_acc <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_en <= (scan_d <= scan_end);
          if (scan_d <= scan_end) begin
            pend_d  <= scan_d;
            scan_d  <= scan_d + 1'b1;
          end
          if (pend_en && (pend_d == scan_end)) begin
            k     <= '0;
            state <= ST_LEVEL;
          end
        end
        ST_LEVEL: begin
          pend_en <= 1'b0;
          if (step_ok) begin
            buy_acc  <= buy_next;
            sell_acc <= sell_next;
            k        <= k + 1'b1;
            if (k == LAST_LVL) begin
              results.buy_flags  <= buy_next;
              results.sell_flags <= sell_next;
              prev_avg           <= avg_r;
              if (sample_count != '1) sample_count <= sample_count + 1'b1;
              state              <= ST_IDLE;
            end
          end
        end
        default: begin
          pend_en <= 1'b0;
          state   <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("request accepted without starting the window scan");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("window fill count beyond depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    pend_en |-> pend_d <= scan_end)
    else $error("window scan read past the longest span");

  a_result_after_last_level: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == ST_LEVEL && $past(k) == LAST_LVL)
    else $error("result raised outside the last level step");
`endif

endmodule

FILE: hdl/plcs_ram.sv
// close price window memory: one write port, one registered read port
// depends on plcs_pkg for depth and widths
module plcs_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [plcs_pkg::ADDR_W-1:0]   wr_addr,
  input  plcs_pkg::price_t              wr_data,
  input  logic [plcs_pkg::ADDR_W-1:0]   rd_addr,
  output plcs_pkg::price_t              rd_data
);

  plcs_pkg::price_t mem [plcs_pkg::WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/plcs_scan.sv
// shared window scan unit: running max/min for both right spans, one close per cycle
// depends on plcs_pkg for scan_ctl_t and scan_res_t
module plcs_scan (
  input  logic                clk,
  input  plcs_pkg::scan_ctl_t ctl,
  input  plcs_pkg::price_t    value,
  output plcs_pkg::scan_res_t res
);

  localparam int SW = plcs_pkg::SPAN_W;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.d == '0) begin
        res.mx_q <= value;
        res.mn_q <= value;
        res.mx_s <= value;
        res.mn_s <= value;
      end else begin
        if (ctl.d <= ctl.span_q) begin
          if (value > res.mx_q) res.mx_q <= value;
          if (value < res.mn_q) res.mn_q <= value;
        end
        if (ctl.d <= ctl.span_s) begin
          if (value > res.mx_s) res.mx_s <= value;
          if (value < res.mn_s) res.mn_s <= value;
        end
      end
      // pivot candidates and the close two samples back
      if (ctl.d == SW'(ctl.right_q)) res.mid_q <= value;
      if (ctl.d == SW'(ctl.right_s)) res.mid_s <= value;
      if (ctl.d == SW'(2)) res.c2 <= value;
    end
  end

endmodule

FILE: hdl/plcs_levels.sv
// support/resistance level store and crossover test, one level per step
// depends on plcs_pkg for lvl_ctl_t, scan_res_t and widths
module plcs_levels (
  input  logic                              clk,
  input  logic                              rst,
  input  plcs_pkg::lvl_ctl_t                ctl,
  input  plcs_pkg::scan_res_t               res,
  input  logic signed [plcs_pkg::AVG_W-1:0] avg,
  input  logic signed [plcs_pkg::AVG_W-1:0] prev_avg,
  output logic                              buy,
  output logic                              sell
);

  localparam int HW = plcs_pkg::HIDX_W;
  localparam int LW = plcs_pkg::LVL_W;

  plcs_pkg::price_t hist [plcs_pkg::LEVEL_COUNT][plcs_pkg::HIST_DEPTH];

  logic             is_quick;
  logic             is_high;
  logic             warm;
  logic             pivot;
  logic [HW-1:0]    j;
  plcs_pkg::price_t mid;
  plcs_pkg::price_t ext;
  plcs_pkg::price_t lvl_now;
  plcs_pkg::price_t lvl_before;

  always_comb begin
    is_quick   = (ctl.k < LW'(2));
    is_high    = !ctl.k[0];
    warm       = is_quick ? ctl.warm_q : ctl.warm_s;
    mid        = is_quick ? res.mid_q : res.mid_s;
    if (is_quick) begin
      ext = is_high ? res.mx_q : res.mn_q;
    end else begin
      ext = is_high ? res.mx_s : res.mn_s;
    end
    pivot      = (mid != '0) && (ext == mid);
    // slow level pairs reuse the value from 1, 2 or 3 samples back
    j          = is_quick ? '0 : HW'(ctl.k[LW-1:1] - 1'b1);
    lvl_before = hist[ctl.k][0];
    if (!warm) begin
      lvl_now = '0;
    end else if (pivot) begin
      lvl_now = mid;
    end else begin
      lvl_now = hist[ctl.k][j];
    end
    buy  = ctl.armed && ctl.rise && (avg > $signed({1'b0, lvl_now}))
           && (prev_avg < $signed({1'b0, lvl_before}));
    sell = ctl.armed && ctl.fall && (avg < $signed({1'b0, lvl_now}))
           && (prev_avg > $signed({1'b0, lvl_before}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < plcs_pkg::LEVEL_COUNT; i++) begin
        for (int h = 0; h < plcs_pkg::HIST_DEPTH; h++) begin
          hist[i][h] <= '0;
        end
      end
    end else if (ctl.step) begin
      hist[ctl.k][2] <= hist[ctl.k][1];
      hist[ctl.k][1] <= hist[ctl.k][0];
      hist[ctl.k][0] <= lvl_now;
    end
  end

endmodule
